// ===== rtl/core/hipp_pkg.sv =====
// ----------------------------------------------------------------------------
// hipp_pkg
// Shared types and constants for the header / ipv4 address / port parser
// ----------------------------------------------------------------------------
package hipp_pkg;

  localparam int HEADER_MAX   = 8;
  localparam int CHAR_W       = 8;
  localparam int PATTERN_W    = HEADER_MAX * CHAR_W;
  localparam int LEN_W        = 4;
  localparam int MATCH_W      = 4;
  localparam int ACC_W        = 16;
  localparam int PORT_W       = 16;
  localparam int OCTET_W      = 8;
  localparam int NUM_OCTETS   = 4;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = PATTERN_W;
  localparam int PROD_W       = ACC_W + 4;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_END      = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_WILDCARD = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_PATTERN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH  = 1'b1;

  localparam logic [LEN_W-1:0] HEADER_MAX_LEN = LEN_W'(HEADER_MAX);

  // parse phase of the current string
  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_OCT1   = 3'd1,
    PH_OCT2   = 3'd2,
    PH_OCT3   = 3'd3,
    PH_OCT4   = 3'd4,
    PH_PORT   = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

endpackage

// ===== rtl/core/header_ip_port_parser.sv =====
// ----------------------------------------------------------------------------
// header_ip_port_parser
// Streams a text string one character per word, finds a configured header
// (with '?' wildcards), then parses a dotted ipv4 address and a decimal port
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | in_char_byte, in_last
//  out      | out_valid / out_ready| out_ok, out_octet_a..d, out_port_number
//  cfg      | cfg_wr_en            | cfg_index, cfg_wdata (write only)
//
//  one character word is taken per cycle while in_ready is high; its result (when
//  the string ends) appears on out in the cycle after acceptance, from the output register
//  the per-character path is a pattern compare plus one multiply by ten
//  (shift-add) and a compare against 255, between state and output registers
//  in_ready drops only while a result sits in the output register and
//  out_ready is low
//  rst_n (synchronous) clears config, parse state and the output valid flag
//
module header_ip_port_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [hipp_pkg::CHAR_W-1:0]        in_char_byte,
  input  logic                               in_last,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic [hipp_pkg::OCTET_W-1:0]       out_octet_a,
  output logic [hipp_pkg::OCTET_W-1:0]       out_octet_b,
  output logic [hipp_pkg::OCTET_W-1:0]       out_octet_c,
  output logic [hipp_pkg::OCTET_W-1:0]       out_octet_d,
  output logic [hipp_pkg::PORT_W-1:0]        out_port_number,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [hipp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hipp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [hipp_pkg::PATTERN_W-1:0] pattern_r;
  logic [hipp_pkg::LEN_W-1:0]     length_r;

  // per-string parse state
  hipp_pkg::phase_t               phase_r, phase_nxt;
  logic [hipp_pkg::MATCH_W-1:0]   match_r, match_nxt;
  logic [hipp_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic [hipp_pkg::OCTET_W-1:0]   store_r   [hipp_pkg::NUM_OCTETS];
  logic [hipp_pkg::OCTET_W-1:0]   store_nxt [hipp_pkg::NUM_OCTETS];
  logic                           ovf_r, ovf_nxt;
  logic                           fail_r, fail_nxt;

  // output register
  logic                           out_valid_r;
  logic                           ok_r, ok_nxt;
  logic [hipp_pkg::OCTET_W-1:0]   oct_r   [hipp_pkg::NUM_OCTETS];
  logic [hipp_pkg::OCTET_W-1:0]   oct_nxt [hipp_pkg::NUM_OCTETS];
  logic [hipp_pkg::PORT_W-1:0]    port_r, port_nxt;

  // datapath helpers
  logic                           accept;
  logic                           take_char;
  logic                           end_of_string;
  logic [hipp_pkg::LEN_W-1:0]     eff_len;
  logic                           is_digit;
  logic [3:0]                     digit_val;
  logic [hipp_pkg::CHAR_W-1:0]    digit_off;
  logic                           header_done;
  hipp_pkg::phase_t               eff_phase;
  logic [hipp_pkg::ACC_W-1:0]     eff_acc;
  logic                           eff_ovf;
  logic [hipp_pkg::PROD_W-1:0]    prod;
  logic [hipp_pkg::CHAR_W-1:0]    pat_char;
  logic [hipp_pkg::CHAR_W-1:0]    pat_first;
  logic [hipp_pkg::MATCH_W-1:0]   match_step;

  // output slot is free or is being emptied this cycle
  assign in_ready      = !out_valid_r || out_ready;
  assign accept        = in_valid && in_ready;
  assign take_char     = accept && (in_char_byte != hipp_pkg::CHAR_END);
  assign end_of_string = accept && ((in_char_byte == hipp_pkg::CHAR_END) || in_last);

  // header length saturates at the pattern size
  assign eff_len = (length_r > hipp_pkg::HEADER_MAX_LEN) ? hipp_pkg::HEADER_MAX_LEN : length_r;

  assign is_digit  = (in_char_byte >= hipp_pkg::CHAR_ZERO) &&
                     (in_char_byte <= hipp_pkg::CHAR_NINE);
  assign digit_off = in_char_byte - hipp_pkg::CHAR_ZERO;
  assign digit_val = digit_off[3:0];

  // header already complete: this character goes straight into octet one
  assign header_done = (phase_r == hipp_pkg::PH_SEARCH) && (match_r >= eff_len);
  assign eff_phase   = header_done ? hipp_pkg::PH_OCT1 : phase_r;
  assign eff_acc     = header_done ? '0 : acc_r;
  assign eff_ovf     = header_done ? 1'b0 : ovf_r;

  // acc * 10 + digit as shift-add
  assign prod = {1'b0, eff_acc, 3'b000} + {3'b000, eff_acc, 1'b0} +
                {{(hipp_pkg::PROD_W-4){1'b0}}, digit_val};

  // pattern characters for the restart rule
  assign pat_char   = pattern_r[{match_r[2:0], 3'b000} +: hipp_pkg::CHAR_W];
  assign pat_first  = pattern_r[hipp_pkg::CHAR_W-1:0];
  assign match_step = match_r + 1'b1;

  // next parse state for one character
  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    fail_nxt  = fail_r;
    store_nxt = store_r;
    if (take_char && !fail_r) begin
      if (header_done) begin
        phase_nxt = hipp_pkg::PH_OCT1;
        acc_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
      unique case (eff_phase)
        hipp_pkg::PH_SEARCH: begin
          if ((pat_char == hipp_pkg::CHAR_WILDCARD) || (in_char_byte == pat_char)) begin
            match_nxt = match_step;
          end else if (in_char_byte == pat_first) begin
            match_nxt = hipp_pkg::MATCH_W'(1);
          end else begin
            match_nxt = '0;
          end
          if (match_nxt >= eff_len) begin
            phase_nxt = hipp_pkg::PH_OCT1;
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        hipp_pkg::PH_OCT1, hipp_pkg::PH_OCT2, hipp_pkg::PH_OCT3, hipp_pkg::PH_OCT4: begin
          if (is_digit) begin
            if (!eff_ovf) begin
              // acc stays below 256 here, so the product fits in 12 bits
              if (prod[hipp_pkg::PROD_W-1:hipp_pkg::OCTET_W] != '0) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = prod[hipp_pkg::ACC_W-1:0];
              end
            end
          end else if (eff_ovf) begin
            fail_nxt = 1'b1;
          end else begin
            unique case (eff_phase)
              hipp_pkg::PH_OCT1: store_nxt[0] = eff_acc[hipp_pkg::OCTET_W-1:0];
              hipp_pkg::PH_OCT2: store_nxt[1] = eff_acc[hipp_pkg::OCTET_W-1:0];
              hipp_pkg::PH_OCT3: store_nxt[2] = eff_acc[hipp_pkg::OCTET_W-1:0];
              default:           store_nxt[3] = eff_acc[hipp_pkg::OCTET_W-1:0];
            endcase
            phase_nxt = hipp_pkg::phase_t'(eff_phase + 3'd1);
            acc_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        hipp_pkg::PH_PORT: begin
          // port wraps modulo 2^16
          if (is_digit) begin
            acc_nxt = prod[hipp_pkg::ACC_W-1:0];
          end else begin
            phase_nxt = hipp_pkg::PH_DONE;
          end
        end
        default: begin
          // port finished: rest of the string is ignored
        end
      endcase
    end
  end

  // result word built from the state after this character
  always_comb begin
    ok_nxt = !fail_nxt && (((phase_nxt == hipp_pkg::PH_OCT4) && !ovf_nxt) ||
                           (phase_nxt == hipp_pkg::PH_PORT) ||
                           (phase_nxt == hipp_pkg::PH_DONE));
    oct_nxt[0] = ok_nxt ? store_nxt[0] : '0;
    oct_nxt[1] = ok_nxt ? store_nxt[1] : '0;
    oct_nxt[2] = ok_nxt ? store_nxt[2] : '0;
    // ending inside octet four closes it from the accumulator
    if (!ok_nxt) begin
      oct_nxt[3] = '0;
    end else if (phase_nxt == hipp_pkg::PH_OCT4) begin
      oct_nxt[3] = acc_nxt[hipp_pkg::OCTET_W-1:0];
    end else begin
      oct_nxt[3] = store_nxt[3];
    end
    port_nxt = (ok_nxt && (phase_nxt != hipp_pkg::PH_OCT4)) ? acc_nxt : '0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hipp_pkg::REG_HEADER_PATTERN: pattern_r <= cfg_wdata;
        hipp_pkg::REG_HEADER_LENGTH:  length_r  <= cfg_wdata[hipp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // parse state, cleared after every result
  always_ff @(posedge clk) begin
    if (!rst_n || end_of_string) begin
      phase_r <= hipp_pkg::PH_SEARCH;
      match_r <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      fail_r  <= 1'b0;
      for (int i = 0; i < hipp_pkg::NUM_OCTETS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      fail_r  <= fail_nxt;
      store_r <= store_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (end_of_string) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (end_of_string) begin
      ok_r   <= ok_nxt;
      oct_r  <= oct_nxt;
      port_r <= port_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_octet_a     = oct_r[0];
  assign out_octet_b     = oct_r[1];
  assign out_octet_c     = oct_r[2];
  assign out_octet_d     = oct_r[3];
  assign out_port_number = port_r;

endmodule

// ===== rtl/core/hipp_checker.sv =====
// ----------------------------------------------------------------------------
// hipp_checker
// Port-level checks for the header / ipv4 address / port parser
// ----------------------------------------------------------------------------
module hipp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [hipp_pkg::CHAR_W-1:0]        in_char_byte,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_ok,
  input logic [hipp_pkg::OCTET_W-1:0]       out_octet_a,
  input logic [hipp_pkg::OCTET_W-1:0]       out_octet_b,
  input logic [hipp_pkg::OCTET_W-1:0]       out_octet_c,
  input logic [hipp_pkg::OCTET_W-1:0]       out_octet_d,
  input logic [hipp_pkg::PORT_W-1:0]        out_port_number
);

  // a failed parse reports all-zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> ((out_octet_a == '0) && (out_octet_b == '0) &&
                                (out_octet_c == '0) && (out_octet_d == '0) &&
                                (out_port_number == '0)))
    else $error("failed result carries nonzero fields");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a pending result");

  // a string end produces a result on the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && ((in_char_byte == hipp_pkg::CHAR_END) || in_last))
      |=> out_valid)
    else $error("string end gave no result");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ok) &&
                                   $stable(out_port_number) && $stable(out_octet_d)))
    else $error("stalled result changed");

endmodule

bind header_ip_port_parser hipp_checker u_hipp_checker (.*);

// ===== test/header_ip_port_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_ip_port_parser_checker
// Watches the character, result and register ports of the parser, keeps its
// own copy of the header search and address parse, and compares each result
// word field by field with the oldest expected address
// ----------------------------------------------------------------------------
module header_ip_port_parser_checker
  import hipp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [CHAR_W-1:0]      in_char_byte,
  input  logic                   in_last,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_ok,
  input  logic [OCTET_W-1:0]     out_octet_a,
  input  logic [OCTET_W-1:0]     out_octet_b,
  input  logic [OCTET_W-1:0]     out_octet_c,
  input  logic [OCTET_W-1:0]     out_octet_d,
  input  logic [PORT_W-1:0]      out_port_number,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic [31:0]            fail_count,
  output logic [31:0]            results_due
);

  localparam int OCTET_MAX = 255;

  typedef struct packed {
    logic               ok;
    logic [OCTET_W-1:0] oct_a;
    logic [OCTET_W-1:0] oct_b;
    logic [OCTET_W-1:0] oct_c;
    logic [OCTET_W-1:0] oct_d;
    logic [PORT_W-1:0]  port;
  } endpoint_t;

  logic [PATTERN_W-1:0] hdr_pattern;
  logic [LEN_W-1:0]     hdr_length;
  logic [MATCH_W-1:0]   hdr_matched;
  phase_t               phase;
  logic [ACC_W-1:0]     acc;
  logic                 acc_over;
  logic                 string_bad;
  logic [OCTET_W-1:0]   octets [NUM_OCTETS];
  endpoint_t            addresses_due [$];
  endpoint_t            head;

  function automatic int header_len_eff();
    return (hdr_length > HEADER_MAX_LEN) ? HEADER_MAX : int'(hdr_length);
  endfunction

  function automatic void clear_string();
    hdr_matched = '0;
    phase       = PH_SEARCH;
    acc         = '0;
    acc_over    = 1'b0;
    string_bad  = 1'b0;
    for (int i = 0; i < NUM_OCTETS; i++) octets[i] = '0;
  endfunction

  function automatic void absorb_char(input logic [CHAR_W-1:0] ch);
    logic              is_digit;
    int                len;
    int                v;
    logic [CHAR_W-1:0] want;
    is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    len      = header_len_eff();
    v        = int'(acc) * 10 + int'(ch) - int'(CHAR_ZERO);
    if (string_bad) return;
    if (phase == PH_SEARCH) begin
      if (int'(hdr_matched) < len) begin
        want = hdr_pattern[CHAR_W*hdr_matched[2:0] +: CHAR_W];
        // restart rule: fall back to one only when the byte opens the header
        if (want == CHAR_WILDCARD || ch == want) hdr_matched = hdr_matched + 1'b1;
        else if (ch == hdr_pattern[CHAR_W-1:0]) hdr_matched = MATCH_W'(1);
        else hdr_matched = '0;
        if (int'(hdr_matched) >= len) begin
          phase    = PH_OCT1;
          acc      = '0;
          acc_over = 1'b0;
        end
        return;
      end
      // header already complete, this byte belongs to the first octet
      phase    = PH_OCT1;
      acc      = '0;
      acc_over = 1'b0;
    end
    if (phase >= PH_OCT1 && phase <= PH_OCT4) begin
      if (is_digit) begin
        if (!acc_over) begin
          if (v > OCTET_MAX) acc_over = 1'b1;
          else acc = ACC_W'(v);
        end
      end else if (acc_over) begin
        string_bad = 1'b1;
      end else begin
        octets[int'(phase) - 1] = acc[OCTET_W-1:0];
        phase = phase_t'(phase + 1);
        acc   = '0;
      end
    end else if (phase == PH_PORT) begin
      if (is_digit) acc = ACC_W'(v);
      else phase = PH_DONE;
    end
  endfunction

  function automatic endpoint_t close_string();
    endpoint_t r;
    r = '0;
    if (!string_bad) begin
      if (phase == PH_OCT4 && !acc_over) begin
        octets[NUM_OCTETS-1] = acc[OCTET_W-1:0];
        r.ok = 1'b1;
      end else if (phase == PH_PORT || phase == PH_DONE) begin
        r.ok   = 1'b1;
        r.port = acc;
      end
    end
    if (r.ok) begin
      r.oct_a = octets[0];
      r.oct_b = octets[1];
      r.oct_c = octets[2];
      r.oct_d = octets[3];
    end
    clear_string();
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [PORT_W-1:0] want,
                                        input logic [PORT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_pattern = '0;
      hdr_length  = '0;
      clear_string();
      addresses_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_HEADER_PATTERN: hdr_pattern = cfg_wdata;
          REG_HEADER_LENGTH:  hdr_length  = cfg_wdata[LEN_W-1:0];
        endcase
      end
      // results first, so a word can never be matched against its own prediction
      if (out_valid && out_ready) begin
        if (addresses_due.size() == 0) begin
          $display("%0t: result expected none actual ok %0d port %0d", $time, out_ok,
                   out_port_number);
          fail_count = fail_count + 1;
        end else begin
          head = addresses_due.pop_front();
          compare_field("ok", PORT_W'(head.ok), PORT_W'(out_ok));
          compare_field("octet_a", PORT_W'(head.oct_a), PORT_W'(out_octet_a));
          compare_field("octet_b", PORT_W'(head.oct_b), PORT_W'(out_octet_b));
          compare_field("octet_c", PORT_W'(head.oct_c), PORT_W'(out_octet_c));
          compare_field("octet_d", PORT_W'(head.oct_d), PORT_W'(out_octet_d));
          compare_field("port_number", head.port, out_port_number);
        end
      end
      if (in_valid && in_ready) begin
        if (in_char_byte != CHAR_END) absorb_char(in_char_byte);
        if (in_char_byte == CHAR_END || in_last) addresses_due.push_back(close_string());
      end
    end
    results_due = addresses_due.size();
  end

endmodule

// ===== test/header_ip_port_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_ip_port_parser_tb
// Streams header / dotted address / port strings through the parser under
// random valid and ready gaps, reprograms the header between runs of strings
// and leaves all checking to the checker module beside the block
// ----------------------------------------------------------------------------
module header_ip_port_parser_tb;
  import hipp_pkg::*;

  localparam int WORD_TARGET = 1900;
  localparam int PHASE_WORDS = 150;
  localparam int LONG_HOLD   = 300;

  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

  // how a string is closed
  typedef enum {END_LAST, END_ZERO, END_OPEN} text_end_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [CHAR_W-1:0]      in_char_byte;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_ok;
  logic [OCTET_W-1:0]     out_octet_a;
  logic [OCTET_W-1:0]     out_octet_b;
  logic [OCTET_W-1:0]     out_octet_c;
  logic [OCTET_W-1:0]     out_octet_d;
  logic [PORT_W-1:0]      out_port_number;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  logic [31:0]            fail_total;
  logic [31:0]            results_due;

  // stimulus state
  int                     words_sent  = 0;
  bit                     tx_idle_on  = 1'b0;
  bit                     rx_idle_on  = 1'b0;
  int                     rx_hold_len = 0;
  int                     setting_no  = 0;
  int                     phase_end;
  logic [PATTERN_W-1:0]   cur_pattern;
  logic [LEN_W-1:0]       cur_length;
  logic [CHAR_W-1:0]      text [$];

  header_ip_port_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_byte    (in_char_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_octet_a     (out_octet_a),
    .out_octet_b     (out_octet_b),
    .out_octet_c     (out_octet_c),
    .out_octet_d     (out_octet_d),
    .out_port_number (out_port_number),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  header_ip_port_parser_checker watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_byte    (in_char_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_octet_a     (out_octet_a),
    .out_octet_b     (out_octet_b),
    .out_octet_c     (out_octet_c),
    .out_octet_d     (out_octet_d),
    .out_port_number (out_port_number),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_total),
    .results_due     (results_due)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random ready bursts, plus one long hold when asked for
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        // long hold counted here, the sender keeps offering words meanwhile
        out_ready <= 1'b0;
        repeat (rx_hold_len - 1) @(negedge clk);
        rx_hold_len = 0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one character word; starts and ends on a falling edge
  task automatic push_word(input logic [CHAR_W-1:0] ch, input logic lst);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= ch;
    in_last      <= lst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    words_sent++;
  endtask

  // stop sending and let every pending result drain out of the block
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    // a string left open may still be in the pipe
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_header(input logic [PATTERN_W-1:0] pat, input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] junk;
    junk        = {$urandom, $urandom};
    cur_pattern = pat;
    cur_length  = len;
    write_reg(REG_HEADER_PATTERN, pat);
    // upper bits of the length write carry junk that must be dropped
    write_reg(REG_HEADER_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
  endtask

  task automatic send_text(input text_end_t how);
    for (int i = 0; i < text.size(); i++)
      push_word(text[i], how == END_LAST && i == text.size() - 1);
    if (how == END_ZERO || (how == END_LAST && text.size() == 0))
      push_word(CHAR_END, 1'($urandom_range(0, 1)));
    text.delete();
  endtask

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic void add_number(input int unsigned value, input int pad);
    repeat (pad) text.push_back(CHAR_ZERO);
    add_str($sformatf("%0d", value));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_nondigit();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  function automatic logic [PATTERN_W-1:0] random_pattern();
    logic [PATTERN_W-1:0] p;
    for (int k = 0; k < HEADER_MAX; k++) begin
      case ($urandom_range(0, 7))
        0, 1:    p[CHAR_W*k +: CHAR_W] = CHAR_WILDCARD;
        2:       p[CHAR_W*k +: CHAR_W] = CHAR_W'($urandom);
        default: p[CHAR_W*k +: CHAR_W] = CHAR_W'($urandom_range(8'h41, 8'h43));
      endcase
    end
    return p;
  endfunction

  // header (sometimes behind junk, damaged or left out), up to four octets, optional port
  function automatic void build_address();
    int                n_hdr;
    int                stop_at;
    int unsigned       val;
    logic [CHAR_W-1:0] pc;
    n_hdr = (cur_length > HEADER_MAX_LEN) ? HEADER_MAX : int'(cur_length);
    // header-like junk up front drives the restart rule
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) begin
        pc = cur_pattern[CHAR_W*$urandom_range(0, HEADER_MAX - 1) +: CHAR_W];
        text.push_back((pc == CHAR_END) ? rand_nondigit() : pc);
      end
    if ($urandom_range(0, 15) != 0)
      for (int k = 0; k < n_hdr; k++) begin
        pc = cur_pattern[CHAR_W*k +: CHAR_W];
        // wildcards take any byte; a zero in the pattern can not be sent
        if (pc == CHAR_WILDCARD || pc == CHAR_END || $urandom_range(0, 31) == 0)
          pc = CHAR_W'($urandom_range(1, 255));
        text.push_back(pc);
      end
    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
    for (int k = 0; k < stop_at; k++) begin
      case ($urandom_range(0, 19))
        0:       ;                                                 // empty octet
        1:       add_number(OCTET_W'(8'hFF), 0);
        2:       add_number($urandom_range(256, 99999), 0);        // too big
        3:       add_number($urandom_range(0, 255), $urandom_range(1, 2));
        default: add_number($urandom_range(0, 255), 0);
      endcase
      if (k < stop_at - 1 || (k < 3 && $urandom_range(0, 1) == 0))
        text.push_back(($urandom_range(0, 7) == 0) ? rand_nondigit() : CH_DOT);
    end
    if (stop_at == 4) begin
      case ($urandom_range(0, 3))
        0: ;                                  // ends inside the fourth octet
        1: text.push_back(rand_nondigit());   // separator, no port digits
        default: begin
          text.push_back(($urandom_range(0, 3) == 0) ? rand_nondigit() : CH_COLON);
          case ($urandom_range(0, 7))
            0:       val = 65535;
            1:       val = 65536 + $urandom_range(0, 65535);
            2:       val = $urandom_range(0, 9);
            default: val = $urandom_range(0, 99999);
          endcase
          add_number(val, 0);
          // trailing text after the port is ignored
          if ($urandom_range(0, 2) == 0) begin
            text.push_back(rand_nondigit());
            add_number($urandom_range(0, 999), 0);
          end
        end
      endcase
    end
  endfunction

  // one header setting per phase, extremes first
  task automatic next_setting();
    case (setting_no)
      0:       set_header('1, 4'd8);
      1:       set_header(random_pattern(), 4'hF);   // above the maximum
      2:       set_header('0, 4'd0);
      3:       set_header('0, 4'd2);                 // zero bytes never match
      default: set_header(random_pattern(), LEN_W'($urandom_range(0, 8)));
    endcase
    setting_no++;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_byte = '0;
    in_last      = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    cur_pattern  = '0;
    cur_length   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset header is empty, so octets start at once
    add_str("7");          // end inside the first octet
    send_text(END_ZERO);
    add_str("255...7");    // 255, empty octets, end in fourth octet digits
    send_text(END_LAST);
    add_str("...:99999/"); // port wraps, then a non-digit freezes it
    send_text(END_LAST);
    add_str("256.1");      // oversized octet fails the string
    send_text(END_LAST);

    // header "A?" plus a zero byte; match two, then shorten the header mid-string
    wait_idle();
    set_header(64'h0000_0000_0000_3F41, 4'd3);
    add_str("AA");
    send_text(END_OPEN);
    wait_idle();
    set_header(cur_pattern, 4'd2);
    add_str("1...9");
    send_text(END_LAST);

    // random strings, a new header every phase
    while (words_sent < WORD_TARGET) begin
      wait_idle();
      next_setting();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      // no idling at all near the end
      if (words_sent >= WORD_TARGET - 200) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0) begin
          // loose bytes, zero and last flag included
          repeat ($urandom_range(1, 6))
            push_word(CHAR_W'($urandom), 1'($urandom_range(0, 3) == 0));
        end else begin
          build_address();
          send_text(text_end_t'($urandom_range(0, 1)));
        end
      end
      // back pressure: results pile up until the input stalls
      if (setting_no == 4) begin
        wait_idle();
        rx_hold_len = LONG_HOLD;
        repeat (8) begin
          build_address();
          send_text(END_LAST);
        end
      end
    end

    wait_idle();
    repeat (16) @(negedge clk);
    if (fail_total == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
